>>> rtl/sv39ptm_pkg.sv
// Shared types, codes and helpers of the Sv39 page table manager.
package sv39ptm_pkg;

  localparam int IDX_W   = 9;
  localparam int VPN_W   = 27;
  localparam int PPN_W   = 44;
  localparam int PERM_W  = 10;
  localparam int ENTRY_W = PPN_W + PERM_W;
  localparam int IN_DATA_W  = 88;
  localparam int OUT_DATA_W = 48;
  localparam int CFG_DATA_W = 48;

  typedef enum logic [1:0] {
    KIND_ADD    = 2'd0,
    KIND_LOOKUP = 2'd1,
    KIND_ERASE  = 2'd2,
    KIND_NONE   = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_MAPPED     = 2'd1,
    ST_NOT_MAPPED = 2'd2,
    ST_EXHAUSTED  = 2'd3
  } status_t;

  function automatic logic [ENTRY_W-1:0] table_entry(input logic [PPN_W-1:0] base,
                                                     input logic [PPN_W-1:0] page);
    logic [PPN_W-1:0] ppn;
    ppn = base + page;
    return {ppn, {(PERM_W-1){1'b0}}, 1'b1};
  endfunction

endpackage

>>> rtl/sv39_page_table_manager.sv
// Sv39 page table manager: walks, fills and clears a three-level table in one entry memory.
//
//  channel  | direction | payload
//  ---------+-----------+------------------------------------------------------------
//  in_      | slave     | tuser: kind; tdata: virtual_page, phys_page, permission
//  out_     | master    | tuser: status; tdata: result_page
//  cfg_     | slave     | tdata: table_base_page
//
// A full walk reads one entry per level, root, middle and leaf, from the registered memory;
// an add that takes table pages writes the pointers, re-reads the leaf and then fills it;
// a walk that stops at the root or middle, and the unused kind, go straight to the response.
// After reset a clearing pass zeroes all TABLE_PAGES*512 entries of the memory, in_tready low.
// A result waits in the output register while the next transaction is accepted; a full
// output register holds the walk in its response step.
module sv39_page_table_manager #(
  parameter int TABLE_PAGES = 8
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // virtual_page [26:0], phys_page [70:27], permission [80:71], zero [87:81]
  input  logic [sv39ptm_pkg::IN_DATA_W-1:0]   in_tdata,
  // kind [1:0]
  input  logic [1:0]                          in_tuser,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // result_page [43:0], zero [47:44]
  output logic [sv39ptm_pkg::OUT_DATA_W-1:0]  out_tdata,
  // status [1:0]
  output logic [1:0]                          out_tuser,
  input  logic                                cfg_tvalid,
  output logic                                cfg_tready,
  // table_base_page [43:0], zero [47:44]
  input  logic [sv39ptm_pkg::CFG_DATA_W-1:0]  cfg_tdata
);

  localparam int PW    = $clog2(TABLE_PAGES);
  localparam int NW    = $clog2(TABLE_PAGES + 1);
  localparam int AW    = PW + sv39ptm_pkg::IDX_W;
  localparam int DEPTH = TABLE_PAGES * 512;
  localparam int EW    = sv39ptm_pkg::ENTRY_W;
  localparam int PPW   = sv39ptm_pkg::PPN_W;
  localparam int IW    = sv39ptm_pkg::IDX_W;

  typedef enum logic [8:0] {
    S_CLEAR = 9'b000000001,
    S_IDLE  = 9'b000000010,
    S_ROOT  = 9'b000000100,
    S_MID   = 9'b000001000,
    S_WROOT = 9'b000010000,
    S_WMID  = 9'b000100000,
    S_RLEAF = 9'b001000000,
    S_LEAF  = 9'b010000000,
    S_RESP  = 9'b100000000
  } state_t;

  logic [EW-1:0] entry_mem [DEPTH];
  logic [EW-1:0] mem_q_r;
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [AW-1:0] mem_raddr;
  logic [EW-1:0] mem_wdata;

  state_t                     state_r, state_nxt;
  logic [AW-1:0]              clr_cnt_r, clr_cnt_nxt;
  logic [NW-1:0]              nf_r, nf_nxt;
  logic [PPW-1:0]             base_r;
  sv39ptm_pkg::kind_t         kind_r;
  logic [IW-1:0]              v2_r, v1_r, v0_r;
  logic [PPW-1:0]             ppn_r;
  logic [sv39ptm_pkg::PERM_W-1:0] perm_r;
  logic [PW-1:0]              mid_r, mid_nxt;
  logic [PW-1:0]              leaf_r, leaf_nxt;
  sv39ptm_pkg::status_t       status_r, status_nxt;
  logic [PPW-1:0]             page_r, page_nxt;
  logic                       out_tvalid_r;
  logic [PPW-1:0]             out_page_r;
  sv39ptm_pkg::status_t       out_status_r;
  logic                       out_load;

  logic                       in_accept;
  logic                       q_valid;
  logic [PPW-1:0]             q_ppn;
  logic [PPW-1:0]             rel;
  logic                       in_pool;
  logic [PW-1:0]              rel_page;
  logic                       is_add;
  logic                       room_two;
  logic                       room_one;
  logic [NW:0]                nf_ext;

  assign in_tready  = (state_r == S_IDLE);
  assign in_accept  = in_tvalid && in_tready;
  assign cfg_tready = 1'b1;
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = {{(sv39ptm_pkg::OUT_DATA_W - PPW){1'b0}}, out_page_r};
  assign out_tuser  = out_status_r;

  assign q_valid  = mem_q_r[0];
  assign q_ppn    = mem_q_r[EW-1:sv39ptm_pkg::PERM_W];
  assign rel      = q_ppn - base_r;
  assign in_pool  = rel < PPW'(TABLE_PAGES);
  assign rel_page = rel[PW-1:0];
  assign is_add   = (kind_r == sv39ptm_pkg::KIND_ADD);
  assign nf_ext   = {1'b0, nf_r};
  assign room_two = (nf_ext + (NW+1)'(2)) <= (NW+1)'(TABLE_PAGES);
  assign room_one = (nf_ext + (NW+1)'(1)) <= (NW+1)'(TABLE_PAGES);

  always_ff @(posedge clk) begin
    if (mem_we) begin
      entry_mem[mem_waddr] <= mem_wdata;
    end
    mem_q_r <= entry_mem[mem_raddr];
  end

  always_comb begin
    state_nxt   = state_r;
    clr_cnt_nxt = clr_cnt_r;
    nf_nxt      = nf_r;
    mid_nxt     = mid_r;
    leaf_nxt    = leaf_r;
    status_nxt  = status_r;
    page_nxt    = page_r;
    mem_we      = 1'b0;
    mem_waddr   = {leaf_r, v0_r};
    mem_wdata   = '0;
    mem_raddr   = {leaf_r, v0_r};
    out_load    = 1'b0;
    case (state_r)
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_cnt_r;
        clr_cnt_nxt = clr_cnt_r + AW'(1);
        if (clr_cnt_r == AW'(DEPTH - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        mem_raddr = {PW'(0), in_tdata[3*IW-1:2*IW]};
        if (in_accept) begin
          status_nxt = sv39ptm_pkg::ST_OK;
          page_nxt   = '0;
          if (sv39ptm_pkg::kind_t'(in_tuser) == sv39ptm_pkg::KIND_NONE) begin
            state_nxt = S_RESP;
          end else begin
            state_nxt = S_ROOT;
          end
        end
      end
      S_ROOT: begin
        mem_raddr = {rel_page, v1_r};
        if (!q_valid) begin
          if (!is_add) begin
            status_nxt = sv39ptm_pkg::ST_NOT_MAPPED;
            state_nxt  = S_RESP;
          end else if (!room_two) begin
            status_nxt = sv39ptm_pkg::ST_EXHAUSTED;
            state_nxt  = S_RESP;
          end else begin
            mid_nxt   = nf_r[PW-1:0];
            leaf_nxt  = PW'(nf_r + NW'(1));
            nf_nxt    = nf_r + NW'(2);
            state_nxt = S_WROOT;
          end
        end else if (!in_pool) begin
          status_nxt = is_add ? sv39ptm_pkg::ST_EXHAUSTED : sv39ptm_pkg::ST_NOT_MAPPED;
          state_nxt  = S_RESP;
        end else begin
          mid_nxt   = rel_page;
          state_nxt = S_MID;
        end
      end
      S_MID: begin
        mem_raddr = {rel_page, v0_r};
        if (!q_valid) begin
          if (!is_add) begin
            status_nxt = sv39ptm_pkg::ST_NOT_MAPPED;
            state_nxt  = S_RESP;
          end else if (!room_one) begin
            status_nxt = sv39ptm_pkg::ST_EXHAUSTED;
            state_nxt  = S_RESP;
          end else begin
            leaf_nxt  = nf_r[PW-1:0];
            nf_nxt    = nf_r + NW'(1);
            state_nxt = S_WMID;
          end
        end else if (!in_pool) begin
          status_nxt = is_add ? sv39ptm_pkg::ST_EXHAUSTED : sv39ptm_pkg::ST_NOT_MAPPED;
          state_nxt  = S_RESP;
        end else begin
          leaf_nxt  = rel_page;
          state_nxt = S_LEAF;
        end
      end
      S_WROOT: begin
        mem_we    = 1'b1;
        mem_waddr = {PW'(0), v2_r};
        mem_wdata = sv39ptm_pkg::table_entry(base_r, PPW'(mid_r));
        state_nxt = S_WMID;
      end
      S_WMID: begin
        mem_we    = 1'b1;
        mem_waddr = {mid_r, v1_r};
        mem_wdata = sv39ptm_pkg::table_entry(base_r, PPW'(leaf_r));
        state_nxt = S_RLEAF;
      end
      S_RLEAF: begin
        state_nxt = S_LEAF;
      end
      S_LEAF: begin
        state_nxt = S_RESP;
        if (is_add) begin
          if (q_valid) begin
            status_nxt = sv39ptm_pkg::ST_MAPPED;
          end else begin
            mem_we    = 1'b1;
            mem_wdata = {ppn_r, perm_r};
          end
        end else if (!q_valid) begin
          status_nxt = sv39ptm_pkg::ST_NOT_MAPPED;
        end else begin
          page_nxt = q_ppn;
          mem_we   = (kind_r == sv39ptm_pkg::KIND_ERASE);
        end
      end
      S_RESP: begin
        if (!out_tvalid_r || out_tready) begin
          out_load  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_CLEAR;
      clr_cnt_r    <= '0;
      nf_r         <= NW'(1);
      base_r       <= PPW'(524288);
      out_tvalid_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      clr_cnt_r <= clr_cnt_nxt;
      nf_r      <= nf_nxt;
      if (cfg_tvalid && cfg_tready) begin
        base_r <= cfg_tdata[PPW-1:0];
      end
      if (out_load) begin
        out_tvalid_r <= 1'b1;
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      kind_r <= sv39ptm_pkg::kind_t'(in_tuser);
      v0_r   <= in_tdata[IW-1:0];
      v1_r   <= in_tdata[2*IW-1:IW];
      v2_r   <= in_tdata[3*IW-1:2*IW];
      ppn_r  <= in_tdata[sv39ptm_pkg::VPN_W +: PPW];
      perm_r <= in_tdata[sv39ptm_pkg::VPN_W + PPW +: sv39ptm_pkg::PERM_W];
    end
    mid_r    <= mid_nxt;
    leaf_r   <= leaf_nxt;
    status_r <= status_nxt;
    page_r   <= page_nxt;
    if (out_load) begin
      out_page_r   <= page_r;
      out_status_r <= status_r;
    end
  end

`ifndef SYNTH
  a_pool_bound: assert property (@(posedge clk) disable iff (!rst_n)
    nf_r <= NW'(TABLE_PAGES))
    else $error("table pool counter beyond pool size");

  a_pool_grows: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> nf_r >= $past(nf_r))
    else $error("table pool counter moved backwards");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("second transaction accepted during a walk");

  a_result_from_resp: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) && !$past(out_tvalid_r) && out_tvalid_r |-> $past(state_r == S_RESP))
    else $error("result raised outside the response step");
`endif

endmodule

>>> test/page_walk_checker.sv
// Page walk checker: mirrors the table pool of the Sv39 manager and compares every result.
module page_walk_checker #(
  parameter int TABLE_PAGES = 8
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  input  logic                                in_tready,
  // virtual_page [26:0], phys_page [70:27], permission [80:71], zero [87:81]
  input  logic [sv39ptm_pkg::IN_DATA_W-1:0]   in_tdata,
  // kind [1:0]
  input  logic [1:0]                          in_tuser,
  input  logic                                out_tvalid,
  input  logic                                out_tready,
  // result_page [43:0], zero [47:44]
  input  logic [sv39ptm_pkg::OUT_DATA_W-1:0]  out_tdata,
  // status [1:0]
  input  logic [1:0]                          out_tuser,
  input  logic                                cfg_tvalid,
  input  logic                                cfg_tready,
  // table_base_page [43:0], zero [47:44]
  input  logic [sv39ptm_pkg::CFG_DATA_W-1:0]  cfg_tdata,
  output int                                  pending,
  output int                                  errors
);

  localparam int ENTRIES = 512;
  localparam int IDX_W   = sv39ptm_pkg::IDX_W;
  localparam int VPN_W   = sv39ptm_pkg::VPN_W;
  localparam int PPN_W   = sv39ptm_pkg::PPN_W;
  localparam int PERM_W  = sv39ptm_pkg::PERM_W;
  localparam int ENTRY_W = sv39ptm_pkg::ENTRY_W;
  localparam logic [PPN_W-1:0] RESET_BASE = 44'd524288;

  typedef struct packed {
    sv39ptm_pkg::status_t status;
    logic [PPN_W-1:0]     page;
  } walk_outcome_t;

  logic [ENTRY_W-1:0] entry_mirror [TABLE_PAGES*ENTRIES];
  int unsigned        next_table;
  logic [PPN_W-1:0]   pool_base;
  walk_outcome_t      expected_walks [$];
  int                 mismatches = 0;

  function automatic int unsigned slot_of(int unsigned page, logic [IDX_W-1:0] idx);
    return page * ENTRIES + idx;
  endfunction

  function automatic bit in_pool(logic [ENTRY_W-1:0] e, output int unsigned page);
    logic [PPN_W-1:0] rel;
    rel = e[ENTRY_W-1:PERM_W] - pool_base;
    page = rel[31:0];
    return rel < TABLE_PAGES;
  endfunction

  function automatic logic [ENTRY_W-1:0] pointer_to(int unsigned page);
    logic [PPN_W-1:0] ppn;
    ppn = pool_base + page;
    return {ppn, {(PERM_W-1){1'b0}}, 1'b1};
  endfunction

  function automatic walk_outcome_t walk_table(sv39ptm_pkg::kind_t kind,
                                               logic [VPN_W-1:0] vp,
                                               logic [PPN_W-1:0] pp, logic [PERM_W-1:0] perm);
    logic [IDX_W-1:0]   v2, v1, v0;
    int unsigned        mid, leaf, need, avail;
    logic [ENTRY_W-1:0] e;
    walk_outcome_t      res;
    bit                 ok;
    v0 = vp[IDX_W-1:0];
    v1 = vp[2*IDX_W-1:IDX_W];
    v2 = vp[3*IDX_W-1:2*IDX_W];
    res.status = sv39ptm_pkg::ST_OK;
    res.page = '0;
    mid = 0;
    leaf = 0;
    case (kind)
      sv39ptm_pkg::KIND_ADD: begin
        avail = (next_table < TABLE_PAGES) ? TABLE_PAGES - next_table : 0;
        need = 0;
        ok = 1'b1;
        e = entry_mirror[slot_of(0, v2)];
        if (!e[0]) begin
          need = 2;
        end else if (!in_pool(e, mid)) begin
          ok = 1'b0;
        end else begin
          e = entry_mirror[slot_of(mid, v1)];
          if (!e[0]) begin
            need = 1;
          end else if (!in_pool(e, leaf)) begin
            ok = 1'b0;
          end
        end
        if (!ok || need > avail) begin
          res.status = sv39ptm_pkg::ST_EXHAUSTED;
        end else begin
          if (need == 2) begin
            mid = next_table;
            next_table++;
            entry_mirror[slot_of(0, v2)] = pointer_to(mid);
          end
          if (need >= 1) begin
            leaf = next_table;
            next_table++;
            entry_mirror[slot_of(mid, v1)] = pointer_to(leaf);
          end
          if (entry_mirror[slot_of(leaf, v0)][0]) begin
            res.status = sv39ptm_pkg::ST_MAPPED;
          end else begin
            entry_mirror[slot_of(leaf, v0)] = {pp, perm};
          end
        end
      end
      sv39ptm_pkg::KIND_LOOKUP, sv39ptm_pkg::KIND_ERASE: begin
        ok = 1'b0;
        e = entry_mirror[slot_of(0, v2)];
        if (e[0] && in_pool(e, mid)) begin
          e = entry_mirror[slot_of(mid, v1)];
          if (e[0] && in_pool(e, leaf)) begin
            ok = entry_mirror[slot_of(leaf, v0)][0];
          end
        end
        if (!ok) begin
          res.status = sv39ptm_pkg::ST_NOT_MAPPED;
        end else begin
          res.page = entry_mirror[slot_of(leaf, v0)][ENTRY_W-1:PERM_W];
          if (kind == sv39ptm_pkg::KIND_ERASE) begin
            entry_mirror[slot_of(leaf, v0)] = '0;
          end
        end
      end
      default: ;
    endcase
    return res;
  endfunction

  task automatic report_mismatch(string msg);
    if (mismatches < 100) begin
      $display("page_walk_checker: %s", msg);
    end
    mismatches++;
  endtask

  always @(posedge clk) begin : watch
    walk_outcome_t got, want;
    if (!rst_n) begin
      foreach (entry_mirror[i]) entry_mirror[i] = '0;
      next_table = 1;
      pool_base = RESET_BASE;
      expected_walks.delete();
    end else begin
      if (out_tvalid && out_tready) begin
        got.status = sv39ptm_pkg::status_t'(out_tuser);
        got.page = out_tdata[PPN_W-1:0];
        if (expected_walks.size() == 0) begin
          report_mismatch($sformatf("result with no request waiting: status %0d page %h",
                                    got.status, got.page));
        end else begin
          want = expected_walks.pop_front();
          if (got.status !== want.status) begin
            report_mismatch($sformatf("status %0d, expected %0d", got.status, want.status));
          end
          if (got.page !== want.page) begin
            report_mismatch($sformatf("result_page %h, expected %h", got.page, want.page));
          end
        end
      end
      if (cfg_tvalid && cfg_tready) begin
        pool_base = cfg_tdata[PPN_W-1:0];
      end
      if (in_tvalid && in_tready) begin
        expected_walks.push_back(walk_table(sv39ptm_pkg::kind_t'(in_tuser),
                                            in_tdata[VPN_W-1:0],
                                            in_tdata[VPN_W+PPN_W-1:VPN_W],
                                            in_tdata[VPN_W+PPN_W+PERM_W-1:VPN_W+PPN_W]));
      end
    end
    pending <= expected_walks.size();
    errors <= mismatches;
  end

endmodule

>>> test/testbench.sv
// Testbench top of the Sv39 page table manager: clock, reset, requests, stalls and verdict.
module testbench;

  localparam int TABLE_PAGES = 8;
  localparam int QUIET_LIMIT = 20000;
  localparam int PHASES = 10;
  localparam int PHASE_ITEMS = 62;
  localparam int IDX_W      = sv39ptm_pkg::IDX_W;
  localparam int VPN_W      = sv39ptm_pkg::VPN_W;
  localparam int PPN_W      = sv39ptm_pkg::PPN_W;
  localparam int PERM_W     = sv39ptm_pkg::PERM_W;
  localparam int IN_DATA_W  = sv39ptm_pkg::IN_DATA_W;
  localparam int OUT_DATA_W = sv39ptm_pkg::OUT_DATA_W;
  localparam int CFG_DATA_W = sv39ptm_pkg::CFG_DATA_W;
  localparam logic [PPN_W-1:0] PAGE_MAX = '1;
  localparam logic [PPN_W-1:0] HOME_BASE = PAGE_MAX - 44'd3;

  logic                  clk;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata = '0;
  logic [1:0]            in_tuser = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic [1:0]            out_tuser;
  logic                  cfg_tvalid = 1'b0;
  logic                  cfg_tready;
  logic [CFG_DATA_W-1:0] cfg_tdata = '0;

  int               pending;
  int               errors;
  int               quiet_cycles = 0;
  int               rx_hold = 0;
  int               rx_roll;
  bit               gaps_on = 1'b1;
  bit               stalls_on = 1'b1;
  logic [VPN_W-1:0] recent_pages [$];

  sv39_page_table_manager #(
    .TABLE_PAGES (TABLE_PAGES)
  ) u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_tvalid (cfg_tvalid),
    .cfg_tready (cfg_tready),
    .cfg_tdata  (cfg_tdata)
  );

  page_walk_checker #(
    .TABLE_PAGES (TABLE_PAGES)
  ) u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_tvalid (cfg_tvalid),
    .cfg_tready (cfg_tready),
    .cfg_tdata  (cfg_tdata),
    .pending    (pending),
    .errors     (errors)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_tvalid && cfg_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("testbench: done, errors");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  always @(posedge clk) begin
    if (rx_hold > 0) begin
      rx_hold <= rx_hold - 1;
    end else if (!stalls_on) begin
      out_tready <= 1'b1;
    end else begin
      rx_roll = $urandom_range(0, 99);
      if (rx_roll < 55) begin
        out_tready <= 1'b1;
        rx_hold <= $urandom_range(0, 12);
      end else if (rx_roll < 93) begin
        out_tready <= 1'b0;
        rx_hold <= $urandom_range(0, 2);
      end else begin
        out_tready <= 1'b0;
        rx_hold <= $urandom_range(8, 40);
      end
    end
  end

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (!gaps_on || r < 50) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [VPN_W-1:0] vpn(int unsigned hi, int unsigned mid, int unsigned lo);
    return {hi[IDX_W-1:0], mid[IDX_W-1:0], lo[IDX_W-1:0]};
  endfunction

  task automatic send_request(sv39ptm_pkg::kind_t kind, logic [VPN_W-1:0] vp,
                              logic [PPN_W-1:0] pp, logic [PERM_W-1:0] perm);
    int gap;
    gap = gap_len();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= kind;
    in_tdata <= {{(IN_DATA_W-VPN_W-PPN_W-PERM_W){1'b0}}, perm, pp, vp};
    do @(posedge clk); while (!in_tready);
    if (kind == sv39ptm_pkg::KIND_ADD) begin
      if (recent_pages.size() >= 32) void'(recent_pages.pop_front());
      recent_pages.push_back(vp);
    end
  endtask

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  task automatic write_base(logic [PPN_W-1:0] base);
    wait_drained();
    cfg_tvalid <= 1'b1;
    cfg_tdata <= {{(CFG_DATA_W-PPN_W){1'b0}}, base};
    do @(posedge clk); while (!cfg_tready);
    cfg_tvalid <= 1'b0;
  endtask

  task automatic send_random(output sv39ptm_pkg::kind_t kind);
    logic [VPN_W-1:0]  vp;
    logic [PPN_W-1:0]  pp;
    logic [PERM_W-1:0] perm;
    logic [IDX_W-1:0]  v2, v1;
    logic [31:0]       w;
    logic [63:0]       wide;
    int                r;
    r = $urandom_range(0, 99);
    if (r < 35) kind = sv39ptm_pkg::KIND_ADD;
    else if (r < 65) kind = sv39ptm_pkg::KIND_LOOKUP;
    else if (r < 92) kind = sv39ptm_pkg::KIND_ERASE;
    else kind = sv39ptm_pkg::KIND_NONE;
    w = $urandom;
    case ($urandom_range(0, 2))
      0: v2 = '0;
      1: v2 = '1;
      default: v2 = w[IDX_W-1:0];
    endcase
    r = $urandom_range(0, 5);
    if (r < 4) v1 = IDX_W'(r);
    else if (r == 4) v1 = '1;
    else v1 = w[2*IDX_W-1:IDX_W];
    w = $urandom;
    r = $urandom_range(0, 99);
    if (r < 55 && recent_pages.size() > 0) begin
      vp = recent_pages[$urandom_range(0, recent_pages.size() - 1)];
    end else if (r < 85) begin
      vp = {v2, v1, w[IDX_W-1:0]};
    end else begin
      vp = w[VPN_W-1:0];
    end
    wide = {$urandom, $urandom};
    pp = wide[PPN_W-1:0];
    w = $urandom;
    perm = w[PERM_W-1:0];
    if ($urandom_range(0, 9) != 0) perm[0] = 1'b1;
    if ($urandom_range(0, 99) == 0) wait_drained();
    send_request(kind, vp, pp, perm);
  endtask

  initial begin : stimulus
    sv39ptm_pkg::kind_t kind;
    int                 n;
    int                 r;
    logic [PPN_W-1:0]   base;
    logic [63:0]        wide;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    write_base(HOME_BASE);

    send_request(sv39ptm_pkg::KIND_LOOKUP, vpn(0, 0, 0), '0, '0);
    send_request(sv39ptm_pkg::KIND_ERASE, vpn(0, 0, 0), '0, '0);
    send_request(sv39ptm_pkg::KIND_ADD, vpn(0, 0, 0), PAGE_MAX, 10'h3FF);
    send_request(sv39ptm_pkg::KIND_LOOKUP, vpn(0, 0, 0), '0, '0);
    send_request(sv39ptm_pkg::KIND_ADD, vpn(0, 0, 0), 44'h123, 10'h001);
    send_request(sv39ptm_pkg::KIND_ADD, vpn(511, 511, 511), '0, 10'h001);
    send_request(sv39ptm_pkg::KIND_LOOKUP, vpn(511, 511, 511), PAGE_MAX, 10'h3FF);
    send_request(sv39ptm_pkg::KIND_ADD, vpn(0, 1, 5), 44'hABCDE, 10'h3FE);
    send_request(sv39ptm_pkg::KIND_LOOKUP, vpn(0, 1, 5), '0, '0);
    send_request(sv39ptm_pkg::KIND_ERASE, vpn(0, 1, 5), '0, '0);
    send_request(sv39ptm_pkg::KIND_ADD, vpn(0, 1, 5), 44'hA5A5A5A5A5A, 10'h155);
    send_request(sv39ptm_pkg::KIND_ERASE, vpn(0, 1, 5), '0, '0);
    send_request(sv39ptm_pkg::KIND_LOOKUP, vpn(0, 1, 5), '0, '0);
    send_request(sv39ptm_pkg::KIND_ADD, vpn(0, 2, 0), 44'h5A5A5A5A5A5, 10'h2AB);
    send_request(sv39ptm_pkg::KIND_ADD, vpn(5, 0, 0), 44'h777, 10'h001);
    send_request(sv39ptm_pkg::KIND_ADD, vpn(0, 3, 511), 44'h888, 10'h0C1);
    send_request(sv39ptm_pkg::KIND_ADD, vpn(0, 4, 0), 44'h999, 10'h001);
    send_request(sv39ptm_pkg::KIND_NONE, '1, PAGE_MAX, 10'h3FF);
    send_request(sv39ptm_pkg::KIND_LOOKUP, vpn(0, 9, 0), '0, '0);
    send_request(sv39ptm_pkg::KIND_LOOKUP, vpn(0, 0, 1), '0, '0);
    write_base('0);
    send_request(sv39ptm_pkg::KIND_LOOKUP, vpn(0, 0, 0), '0, '0);
    send_request(sv39ptm_pkg::KIND_ADD, vpn(0, 0, 7), 44'h111, 10'h001);
    send_request(sv39ptm_pkg::KIND_ERASE, vpn(511, 511, 511), '0, '0);

    for (int p = 0; p < PHASES; p++) begin
      r = $urandom_range(0, 9);
      wide = {$urandom, $urandom};
      if (p == 0 || p == PHASES - 1) base = HOME_BASE;
      else if (p == 1) base = PAGE_MAX;
      else if (r == 0) base = '0;
      else if (r == 1) base = HOME_BASE + $urandom_range(1, 6);
      else if (r == 2) base = wide[PPN_W-1:0];
      else if (r == 3) base = 44'd524288;
      else base = HOME_BASE;
      write_base(base);
      gaps_on = ($urandom_range(0, 3) != 0);
      stalls_on = ($urandom_range(0, 3) != 0);
      n = 0;
      while (n < PHASE_ITEMS) begin
        send_random(kind);
        if (kind != sv39ptm_pkg::KIND_NONE) n++;
      end
    end

    wait_drained();
    repeat (20) @(posedge clk);
    if (errors == 0 && pending == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule
